// ===== rtl/core/ssba_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Slab slot bitmap allocator package
// Shared constants, codes, control structs and small helper functions.
// ----------------------------------------------------------------------------
package ssba_pkg;

  localparam int ARENA_BYTES = 16384;
  localparam int MAP_WORDS   = 16;
  localparam int WORD_BITS   = 64;
  localparam int WORD_AW     = $clog2(MAP_WORDS);
  localparam int BIT_AW      = $clog2(WORD_BITS);
  localparam int SLOT_W      = WORD_AW + BIT_AW;
  localparam int OFF_W       = 14;
  localparam int COUNT_W     = 10;
  localparam int CLASS_W     = 3;
  localparam int STATUS_W    = 3;
  localparam int SHIFT_W     = 4;
  localparam int WIDE_W      = OFF_W + 4;

  localparam logic [CLASS_W-1:0] CLASS_MAX = 3'd4;

  typedef enum logic [1:0] {
    CMD_ALLOC  = 2'd0,
    CMD_FREE   = 2'd1,
    CMD_FORMAT = 2'd2,
    CMD_NOP    = 2'd3
  } command_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK          = 3'd0,
    STAT_FULL        = 3'd1,
    STAT_MISALIGNED  = 3'd2,
    STAT_HEADER      = 3'd3,
    STAT_DOUBLE_FREE = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE   = 2'd0,
    S_LOOKUP = 2'd1,
    S_UPDATE = 2'd2
  } state_t;

  typedef struct packed {
    logic latch;
    logic lookup;
    logic commit;
  } dp_cmd_t;

  function automatic logic [SHIFT_W-1:0] slot_shift(input logic [CLASS_W-1:0] cls);
    return {1'b0, cls} + 4'd4;
  endfunction

  function automatic logic [3:0] head_slots(input logic [CLASS_W-1:0] cls);
    logic [3:0] r;
    case (cls)
      3'd0:    r = 4'd10;
      3'd1:    r = 4'd3;
      default: r = 4'd1;
    endcase
    return r;
  endfunction

  function automatic logic [COUNT_W-1:0] fmt_free(input logic [CLASS_W-1:0] cls);
    logic [COUNT_W-1:0] r;
    case (cls)
      3'd0:    r = 10'd1014;
      3'd1:    r = 10'd509;
      3'd2:    r = 10'd255;
      3'd3:    r = 10'd127;
      default: r = 10'd63;
    endcase
    return r;
  endfunction

  function automatic logic [MAP_WORDS-1:0] word_mask(input logic [CLASS_W-1:0] cls);
    logic [MAP_WORDS-1:0] r;
    case (cls)
      3'd0:    r = 16'hFFFF;
      3'd1:    r = 16'h00FF;
      3'd2:    r = 16'h000F;
      3'd3:    r = 16'h0003;
      default: r = 16'h0001;
    endcase
    return r;
  endfunction

  // Contents of a bitmap word right after a format.
  function automatic logic [WORD_BITS-1:0] fmt_word(input logic [CLASS_W-1:0] cls,
                                                    input logic [WORD_AW-1:0] w);
    logic [MAP_WORDS-1:0] m;
    logic [WORD_BITS-1:0] r;
    m = word_mask(cls);
    if (!m[w]) begin
      r = '0;
    end else if (w == '0) begin
      r = ~((64'd1 << head_slots(cls)) - 64'd1);
    end else begin
      r = '1;
    end
    return r;
  endfunction

  function automatic logic [2:0] ffs8(input logic [7:0] v);
    logic [2:0] r;
    r = '0;
    for (int i = 7; i >= 0; i--) begin
      if (v[i]) r = 3'(i);
    end
    return r;
  endfunction

  function automatic logic [3:0] ffs16(input logic [15:0] v);
    logic [3:0] r;
    if (v[7:0] != '0) r = {1'b0, ffs8(v[7:0])};
    else r = {1'b1, ffs8(v[15:8])};
    return r;
  endfunction

  function automatic logic [5:0] ffs64(input logic [63:0] v);
    logic [7:0] nz;
    logic [2:0] idx;
    logic [7:0] sel;
    for (int i = 0; i < 8; i++) begin
      nz[i] = (v[i*8 +: 8] != '0);
    end
    idx = ffs8(nz);
    sel = v[{idx, 3'b000} +: 8];
    return {idx, ffs8(sel)};
  endfunction

endpackage
`default_nettype wire

// ===== rtl/core/slab_slot_bitmap_allocator_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Slab slot bitmap allocator
// Allocates and frees equal slots of one 16 KB arena from a free bitmap.
// ----------------------------------------------------------------------------
// Each transaction goes from acceptance to a registered result through an
// accept step, a step that picks the bitmap word and reads it, and a step that
// updates it and loads the result, which waits while the last result is held.
// This order is set by the read-modify-write of a single 64-bit bitmap word in
// a memory with registered read data, and a new transaction is accepted only
// after the last one has loaded its result. Formatting, whether by command or
// by a write of the class register, takes effect through per-word valid bits,
// and there is no clearing pass after reset. The class register is written
// only while the block is idle; values above four behave as class four.
module slab_slot_bitmap_allocator_unit
  import ssba_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire logic [1:0]          command,
  input  wire logic [OFF_W-1:0]    slot_offset,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic      [STATUS_W-1:0] status,
  output logic      [OFF_W-1:0]    claimed_offset,
  output logic      [COUNT_W-1:0]  free_slots,
  output logic                     arena_full,
  input  wire logic                cfg_valid,
  output logic                     cfg_ready,
  input  wire logic [CLASS_W-1:0]  slot_class
);

  dp_cmd_t cmd;

  ssba_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .cfg_ready (cfg_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  ssba_dp u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .command        (command),
    .slot_offset    (slot_offset),
    .cfg_we         (cfg_valid && cfg_ready),
    .cfg_class      (slot_class),
    .status         (status),
    .claimed_offset (claimed_offset),
    .free_slots     (free_slots),
    .arena_full     (arena_full)
  );

endmodule
`default_nettype wire

// ===== rtl/core/ssba_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module ssba_ram #(
  parameter int WIDTH  = 64,
  parameter int DEPTH  = 16,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [WIDTH-1:0]  wdata,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== rtl/core/ssba_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Slab allocator controller
// Sequences each transaction through accept, word lookup and update.
// ----------------------------------------------------------------------------
module ssba_ctrl
  import ssba_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic      in_ready,
  output logic      cfg_ready,
  output logic      out_valid,
  input  wire logic out_ready,
  output dp_cmd_t   cmd
);

  state_t state, state_next;
  logic   out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    cfg_ready  = 1'b0;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        in_ready  = 1'b1;
        cfg_ready = !in_valid && !out_valid;
        cmd.latch = in_valid;
        if (in_valid) state_next = S_LOOKUP;
      end
      S_LOOKUP: begin
        cmd.lookup = 1'b1;
        state_next = S_UPDATE;
      end
      S_UPDATE: begin
        cmd.commit = !out_valid || out_ready;
        if (cmd.commit) state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
    if (cmd.commit) out_valid_next = 1'b1;
    else if (out_ready) out_valid_next = 1'b0;
    else out_valid_next = out_valid;
  end

endmodule
`default_nettype wire

// ===== rtl/core/ssba_dp.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Slab allocator datapath
// Free bitmap memory, word summary, free count and the result register.
// ----------------------------------------------------------------------------
module ssba_dp
  import ssba_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire dp_cmd_t             cmd,
  input  wire logic [1:0]          command,
  input  wire logic [OFF_W-1:0]    slot_offset,
  input  wire logic                cfg_we,
  input  wire logic [CLASS_W-1:0]  cfg_class,
  output logic      [STATUS_W-1:0] status,
  output logic      [OFF_W-1:0]    claimed_offset,
  output logic      [COUNT_W-1:0]  free_slots,
  output logic                     arena_full
);

  logic [CLASS_W-1:0]   cls;
  command_t             item_cmd;
  logic [OFF_W-1:0]     item_off;
  logic [WORD_AW-1:0]   word_addr;
  logic [BIT_AW-1:0]    bit_idx;
  status_t              pre_status;
  logic [MAP_WORDS-1:0] word_valid;
  logic [MAP_WORDS-1:0] summary;
  logic [COUNT_W-1:0]   free_count;

  logic [CLASS_W-1:0]   cfg_cls;
  logic [SHIFT_W-1:0]   shift;
  logic [MAP_WORDS-1:0] live;
  logic [OFF_W-1:0]     slot_full;
  logic [SLOT_W-1:0]    slot;
  logic                 misaligned;
  logic                 header_hit;
  logic [WORD_AW-1:0]   lookup_word;
  status_t              lookup_status;
  logic [WORD_AW-1:0]   raddr;
  logic [WORD_BITS-1:0] rdata;
  logic [WORD_BITS-1:0] cur_word;
  logic [BIT_AW-1:0]    alloc_bit;
  logic [WORD_BITS-1:0] new_word;
  logic                 mem_we;
  logic                 alloc_ok;
  logic                 free_ok;
  status_t              final_status;
  logic [COUNT_W-1:0]   count_next;
  logic [WIDE_W-1:0]    claimed_wide;
  logic [OFF_W-1:0]     claimed_next;

  assign cfg_cls = (cfg_class > CLASS_MAX) ? CLASS_MAX : cfg_class;
  assign shift   = slot_shift(cls);
  assign live    = summary & word_mask(cls);

  always_comb begin
    slot_full     = item_off >> shift;
    slot          = slot_full[SLOT_W-1:0];
    misaligned    = (item_off & ((14'd1 << shift) - 14'd1)) != '0;
    header_hit    = slot < {6'd0, head_slots(cls)};
    lookup_word   = (item_cmd == CMD_ALLOC) ? ffs16(live) : slot[SLOT_W-1:BIT_AW];
    lookup_status = STAT_OK;
    case (item_cmd)
      CMD_ALLOC: begin
        if (live == '0) lookup_status = STAT_FULL;
      end
      CMD_FREE: begin
        if (misaligned) lookup_status = STAT_MISALIGNED;
        else if (header_hit) lookup_status = STAT_HEADER;
      end
      default: begin
        lookup_status = STAT_OK;
      end
    endcase
  end

  assign raddr = cmd.lookup ? lookup_word : word_addr;

  ssba_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (MAP_WORDS)
  ) u_map (
    .clk   (clk),
    .we    (mem_we),
    .waddr (word_addr),
    .wdata (new_word),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_comb begin
    cur_word     = word_valid[word_addr] ? rdata : fmt_word(cls, word_addr);
    alloc_bit    = ffs64(cur_word);
    alloc_ok     = (item_cmd == CMD_ALLOC) && (pre_status == STAT_OK);
    free_ok      = (item_cmd == CMD_FREE) && (pre_status == STAT_OK) && !cur_word[bit_idx];
    new_word     = cur_word;
    final_status = pre_status;
    count_next   = free_count;
    claimed_next = '0;
    claimed_wide = WIDE_W'({word_addr, alloc_bit}) << shift;
    case (item_cmd)
      CMD_ALLOC: begin
        if (alloc_ok) begin
          new_word     = cur_word & ~(64'd1 << alloc_bit);
          claimed_next = claimed_wide[OFF_W-1:0];
          if (free_count != '0) count_next = free_count - 10'd1;
        end
      end
      CMD_FREE: begin
        if (free_ok) begin
          new_word   = cur_word | (64'd1 << bit_idx);
          count_next = free_count + 10'd1;
        end else if (pre_status == STAT_OK) begin
          final_status = STAT_DOUBLE_FREE;
        end
      end
      CMD_FORMAT: begin
        count_next = fmt_free(cls);
      end
      default: begin
        count_next = free_count;
      end
    endcase
    mem_we = cmd.commit && (alloc_ok || free_ok);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cls        <= '0;
      word_valid <= '0;
      summary    <= word_mask('0);
      free_count <= fmt_free('0);
    end else if (cfg_we) begin
      cls        <= cfg_cls;
      word_valid <= '0;
      summary    <= word_mask(cfg_cls);
      free_count <= fmt_free(cfg_cls);
    end else if (cmd.commit) begin
      free_count <= count_next;
      if (item_cmd == CMD_FORMAT) begin
        word_valid <= '0;
        summary    <= word_mask(cls);
      end else if (alloc_ok || free_ok) begin
        word_valid[word_addr] <= 1'b1;
        summary[word_addr]    <= new_word != '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      item_cmd <= command_t'(command);
      item_off <= slot_offset;
    end
    if (cmd.lookup) begin
      word_addr  <= lookup_word;
      bit_idx    <= slot[BIT_AW-1:0];
      pre_status <= lookup_status;
    end
    if (cmd.commit) begin
      status         <= final_status;
      claimed_offset <= claimed_next;
      free_slots     <= count_next;
      arena_full     <= count_next == '0;
    end
  end

  a_count_matches_summary: assert property (@(posedge clk) disable iff (rst)
    (free_count == '0) == (live == '0))
    else $error("free count and word summary disagree");

  a_summary_in_range: assert property (@(posedge clk) disable iff (rst)
    (summary & ~word_mask(cls)) == '0)
    else $error("summary marks a word outside the arena");

  a_count_bounded: assert property (@(posedge clk) disable iff (rst)
    free_count <= fmt_free(cls))
    else $error("free count exceeds the slots of the class");

  a_alloc_takes_one: assert property (@(posedge clk) disable iff (rst)
    cmd.commit && alloc_ok |=> free_count == $past(free_count) - 10'd1)
    else $error("successful alloc did not consume exactly one slot");

endmodule
`default_nettype wire

// ===== bench/tb_slab_slot_bitmap_allocator_unit.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Slab slot bitmap allocator testbench
// Drives alloc, free, format and unused commands through directed and random
// size classes, predicts each result from a shadow free bitmap and compares every field
// of every returned transaction, with random idling on both sides.
// ----------------------------------------------------------------------------
module tb_slab_slot_bitmap_allocator_unit;
  import ssba_pkg::*;

  localparam int HEADER_BYTES  = 24;
  localparam int MAX_WAIT      = 13;
  localparam int SETTLE_CYCLES = 8;
  localparam int RANDOM_ITEMS  = 630;
  localparam int CYCLE_LIMIT   = 400000;

  typedef struct packed {
    status_t             code;
    logic [OFF_W-1:0]    offset;
    logic [COUNT_W-1:0]  count;
    logic                full;
  } slab_result_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [1:0]          command = CMD_NOP;
  logic [OFF_W-1:0]    slot_offset = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [STATUS_W-1:0] status;
  logic [OFF_W-1:0]    claimed_offset;
  logic [COUNT_W-1:0]  free_slots;
  logic                arena_full;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [CLASS_W-1:0]  slot_class = '0;

  slab_result_t        pending_results[$];
  slab_result_t        oldest;
  logic [OFF_W-1:0]    live_offsets[$];
  int                  fail_count = 0;
  int                  cycle_count = 0;
  bit                  quiet = 1'b0;

  logic [WORD_BITS-1:0] shadow_map[MAP_WORDS];
  logic [MAP_WORDS-1:0] shadow_nonempty;
  logic [CLASS_W-1:0]   shadow_class;
  int                   shadow_free;
  int                   geo_shift;
  int                   geo_words;
  int                   geo_valid;
  int                   geo_header;

  slab_slot_bitmap_allocator_unit i_dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .command        (command),
    .slot_offset    (slot_offset),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .status         (status),
    .claimed_offset (claimed_offset),
    .free_slots     (free_slots),
    .arena_full     (arena_full),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .slot_class     (slot_class)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  function automatic int draw_wait();
    return quiet ? 0 : $urandom_range(0, MAX_WAIT);
  endfunction

  function automatic int lowest_set(input logic [WORD_BITS-1:0] v);
    int i;
    i = 0;
    while (i < WORD_BITS - 1 && !v[i]) i++;
    return i;
  endfunction

  // Rebuilds the slot geometry for the current class and marks every
  // slot past the header free.
  function automatic void format_shadow();
    int eff;
    int slots;
    int sb;
    int s;
    eff = (shadow_class > CLASS_MAX) ? CLASS_MAX : shadow_class;
    geo_shift = eff + 4;
    slots = ARENA_BYTES >> geo_shift;
    geo_words = (slots + WORD_BITS - 1) / WORD_BITS;
    if (geo_words > MAP_WORDS) geo_words = MAP_WORDS;
    geo_valid = (slots < geo_words * WORD_BITS) ? slots : geo_words * WORD_BITS;
    sb = 1 << geo_shift;
    geo_header = (HEADER_BYTES + geo_words * 8 + sb - 1) / sb;
    if (geo_header > geo_valid) geo_header = geo_valid;
    for (int w = 0; w < MAP_WORDS; w++) begin
      for (int b = 0; b < WORD_BITS; b++) begin
        s = w * WORD_BITS + b;
        shadow_map[w][b] = (s >= geo_header) && (s < geo_valid);
      end
      shadow_nonempty[w] = |shadow_map[w];
    end
    shadow_free = geo_valid - geo_header;
    live_offsets.delete();
  endfunction

  function automatic slab_result_t apply_command(input command_t cmd,
                                                 input logic [OFF_W-1:0] off);
    slab_result_t         r;
    logic [MAP_WORDS-1:0] live;
    logic [MAP_WORDS:0]   span;
    int                   w;
    int                   b;
    int                   slot;
    r = '0;
    r.code = STAT_OK;
    case (cmd)
      CMD_ALLOC: begin
        span = (1 << geo_words) - 1;
        live = shadow_nonempty & span[MAP_WORDS-1:0];
        if (live == '0) begin
          r.code = STAT_FULL;
        end else begin
          w = lowest_set(live);
          b = lowest_set(shadow_map[w]);
          shadow_map[w][b] = 1'b0;
          shadow_nonempty[w] = |shadow_map[w];
          if (shadow_free > 0) shadow_free--;
          r.offset = OFF_W'((w * WORD_BITS + b) << geo_shift);
          live_offsets.push_back(r.offset);
        end
      end
      CMD_FREE: begin
        slot = off >> geo_shift;
        if ((off & ((1 << geo_shift) - 1)) != 0) begin
          r.code = STAT_MISALIGNED;
        end else if (slot < geo_header || slot >= geo_valid) begin
          r.code = STAT_HEADER;
        end else if (shadow_map[slot / WORD_BITS][slot % WORD_BITS]) begin
          r.code = STAT_DOUBLE_FREE;
        end else begin
          shadow_map[slot / WORD_BITS][slot % WORD_BITS] = 1'b1;
          shadow_nonempty[slot / WORD_BITS] = 1'b1;
          shadow_free++;
          for (int i = 0; i < live_offsets.size(); i++) begin
            if (live_offsets[i] == off) begin
              live_offsets.delete(i);
              break;
            end
          end
        end
      end
      CMD_FORMAT: format_shadow();
      default: ;
    endcase
    r.count = (shadow_free > 1023) ? COUNT_W'(1023) : COUNT_W'(shadow_free);
    r.full = (shadow_free == 0);
    return r;
  endfunction

  task automatic send_item(input command_t cmd, input logic [OFF_W-1:0] off);
    int gap;
    gap = draw_wait();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    command <= cmd;
    slot_offset <= off;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_results.push_back(apply_command(cmd, off));
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_class(input logic [CLASS_W-1:0] cls);
    settle();
    cfg_valid <= 1'b1;
    slot_class <= cls;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    shadow_class = cls;
    format_shadow();
  endtask

  initial begin
    int stall;
    @(posedge clk);
    forever begin
      stall = draw_wait();
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (rst || !out_valid) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result transaction: status %0d offset %0d", status,
               claimed_offset);
        fail_count++;
      end else begin
        oldest = pending_results.pop_front();
        if (status !== oldest.code) begin
          $error("status: expected %0d, got %0d", oldest.code, status);
          fail_count++;
        end
        if (claimed_offset !== oldest.offset) begin
          $error("claimed_offset: expected %0d, got %0d", oldest.offset, claimed_offset);
          fail_count++;
        end
        if (free_slots !== oldest.count) begin
          $error("free_slots: expected %0d, got %0d", oldest.count, free_slots);
          fail_count++;
        end
        if (arena_full !== oldest.full) begin
          $error("arena_full: expected %0d, got %0d", oldest.full, arena_full);
          fail_count++;
        end
      end
    end
  end

  task automatic test_reset_arena();
    send_item(CMD_ALLOC, 14'd0);
    send_item(CMD_FREE, 14'd160);
    send_item(CMD_FREE, 14'd160);
    send_item(CMD_FREE, 14'd0);
    send_item(CMD_FREE, 14'd144);
    send_item(CMD_FREE, 14'd161);
    send_item(CMD_FREE, 14'd16383);
    send_item(CMD_FREE, 14'd16368);
    send_item(CMD_NOP, 14'd16383);
    send_item(CMD_ALLOC, 14'd16383);
    send_item(CMD_FORMAT, 14'd0);
  endtask

  task automatic test_class_edges();
    write_class(3'd7);
    send_item(CMD_ALLOC, 14'd0);
    send_item(CMD_FREE, 14'd256);
    send_item(CMD_FREE, 14'd255);
    send_item(CMD_FREE, 14'd0);
    send_item(CMD_FREE, 14'd16128);
    write_class(3'd1);
    send_item(CMD_ALLOC, 14'd0);
    send_item(CMD_FREE, 14'd16352);
    send_item(CMD_FORMAT, 14'd16383);
  endtask

  // Phases zero and two fill the two classes with fewest slots, mostly allocs;
  // phase one uses class zero, later ones random classes, weights and idling.
  task automatic test_random_traffic();
    int                 phase;
    int                 sent;
    int                 run_len;
    int                 alloc_pct;
    int                 misc_pct;
    int                 roll;
    int                 pick;
    logic [CLASS_W-1:0] cls;
    logic [OFF_W-1:0]   off;
    phase = 0;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      misc_pct = 6;
      alloc_pct = 30 + 20 * $urandom_range(0, 2);
      run_len = $urandom_range(40, 80);
      cls = CLASS_W'($urandom_range(0, 7));
      case (phase)
        0: begin
          cls = 3'd7;
          alloc_pct = 95;
          misc_pct = 0;
          run_len = 90;
        end
        1: cls = 3'd0;
        2: begin
          cls = 3'd3;
          alloc_pct = 94;
          misc_pct = 0;
          run_len = 150;
        end
        default: ;
      endcase
      if (run_len > RANDOM_ITEMS - sent) run_len = RANDOM_ITEMS - sent;
      write_class(cls);
      quiet = ($urandom_range(0, 3) == 0);
      for (int i = 0; i < run_len; i++) begin
        roll = $urandom_range(0, 99);
        off = OFF_W'($urandom_range(0, 16383));
        if (roll < misc_pct) begin
          send_item((roll % 2 == 0) ? CMD_FORMAT : CMD_NOP, off);
        end else if (roll < misc_pct + alloc_pct) begin
          send_item(CMD_ALLOC, off);
        end else begin
          pick = $urandom_range(0, 99);
          if (pick < 70 && live_offsets.size() > 0) begin
            off = live_offsets[$urandom_range(0, live_offsets.size() - 1)];
          end else if (pick < 85) begin
            off = (off >> geo_shift) << geo_shift;
          end else if (pick >= 93) begin
            off = OFF_W'($urandom_range(0, geo_header - 1) << geo_shift);
          end
          send_item(CMD_FREE, off);
        end
      end
      sent += run_len;
      phase++;
    end
    quiet = 1'b0;
  endtask

  initial begin
    shadow_class = '0;
    format_shadow();
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_arena();
    test_class_edges();
    test_random_traffic();
    settle();
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
